// ----- sv/ctd_pkg.sv -----
`default_nettype none

package ctd_pkg;

    localparam int SUM_W = 30;
    localparam int CNT_W = 21;
    localparam int COORD_W = 10;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [7:0]  THRESHOLD_RESET = 8'd100;
    localparam logic [10:0] WIDTH_RESET     = 11'd640;

    // APB register map: one 32-bit register per word.
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_WIDTH     = 1'b1;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [7:0] pixel_value;
        logic       end_of_frame;
    } pixel_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic [CNT_W-1:0]   pixel_count;
        logic               found;
    } result_word_t;

    // Frame totals handed from the accumulator to the divider.
    typedef struct packed {
        logic [SUM_W-1:0] sum_x;
        logic [SUM_W-1:0] sum_y;
        logic [CNT_W-1:0] count;
    } totals_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } back_state_t;

endpackage

`default_nettype wire

// ----- sv/ctd_front.sv -----
`default_nettype none

module ctd_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire ctd_pkg::pixel_word_t   s_data,
    input  wire logic [7:0]             threshold,
    input  wire logic [10:0]            image_width,
    input  wire ctd_pkg::queue_status_t q_status,
    output logic                        push,
    output ctd_pkg::totals_t            push_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CMP_W = (CW + 2 > 12) ? CW + 2 : 12;

    logic [CW-1:0]             column_reg, column_next;
    logic [RW-1:0]             row_reg, row_next;
    logic [ctd_pkg::SUM_W-1:0] sum_x_reg, sum_x_next;
    logic [ctd_pkg::SUM_W-1:0] sum_y_reg, sum_y_next;
    logic [ctd_pkg::CNT_W-1:0] count_reg, count_next;

    logic                      accept;
    logic                      hit;
    logic [ctd_pkg::SUM_W:0]   add_x, add_y;
    logic [ctd_pkg::SUM_W-1:0] acc_x, acc_y;
    logic [ctd_pkg::CNT_W-1:0] acc_count;
    logic [CMP_W-1:0]          width_ext, width_eff, column_inc;
    logic [RW:0]               row_inc;

    assign s_ready = !q_status.full;
    assign accept  = s_valid && s_ready;

    assign hit = (s_data.pixel_value >= threshold) && (count_reg != ctd_pkg::CNT_MAX);

    assign add_x = {1'b0, sum_x_reg} + (ctd_pkg::SUM_W + 1)'(column_reg);
    assign add_y = {1'b0, sum_y_reg} + (ctd_pkg::SUM_W + 1)'(row_reg);

    always_comb begin
        acc_x     = sum_x_reg;
        acc_y     = sum_y_reg;
        acc_count = count_reg;
        if (hit) begin
            acc_x     = add_x[ctd_pkg::SUM_W] ? ctd_pkg::SUM_MAX : add_x[ctd_pkg::SUM_W-1:0];
            acc_y     = add_y[ctd_pkg::SUM_W] ? ctd_pkg::SUM_MAX : add_y[ctd_pkg::SUM_W-1:0];
            acc_count = count_reg + 1'b1;
        end
    end

    // Width zero behaves as one; anything above the maximum is clamped.
    assign width_ext  = CMP_W'(image_width);
    assign width_eff  = (image_width == 11'd0) ? CMP_W'(1) :
                        (width_ext > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : width_ext;
    assign column_inc = CMP_W'(column_reg) + CMP_W'(1);
    assign row_inc    = (RW + 1)'(row_reg) + (RW + 1)'(1);

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        sum_x_next  = sum_x_reg;
        sum_y_next  = sum_y_reg;
        count_next  = count_reg;
        if (accept) begin
            if (s_data.end_of_frame) begin
                column_next = '0;
                row_next    = '0;
                sum_x_next  = '0;
                sum_y_next  = '0;
                count_next  = '0;
            end else begin
                sum_x_next = acc_x;
                sum_y_next = acc_y;
                count_next = acc_count;
                if (column_inc >= width_eff) begin
                    column_next = '0;
                    if (row_inc < (RW + 1)'(MAX_HEIGHT)) begin
                        row_next = row_inc[RW-1:0];
                    end
                end else begin
                    column_next = column_inc[CW-1:0];
                end
            end
        end
    end

    assign push              = accept && s_data.end_of_frame;
    assign push_data.sum_x   = acc_x;
    assign push_data.sum_y   = acc_y;
    assign push_data.count   = acc_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            count_reg  <= '0;
        end else begin
            column_reg <= column_next;
            row_reg    <= row_next;
            sum_x_reg  <= sum_x_next;
            sum_y_reg  <= sum_y_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ctd_queue.sv -----
`default_nettype none

module ctd_queue (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire ctd_pkg::totals_t       push_data,
    input  wire logic                   pop,
    output ctd_pkg::queue_status_t      status,
    output ctd_pkg::totals_t            head
);

    localparam int PTR_W = $clog2(ctd_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(ctd_pkg::QUEUE_DEPTH + 1);

    ctd_pkg::totals_t  entry_reg [ctd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    assign status.full  = (fill_reg == FILL_W'(ctd_pkg::QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ctd_pkg::QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ctd_pkg::QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/ctd_back.sv -----
`default_nettype none

module ctd_back #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire ctd_pkg::queue_status_t q_status,
    input  wire ctd_pkg::totals_t       q_head,
    output logic                        q_pop,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output ctd_pkg::result_word_t       m_data
);

    localparam int SW = ctd_pkg::SUM_W;
    localparam int NW = ctd_pkg::CNT_W;
    localparam int STEP_W = $clog2(SW);
    localparam logic [SW-1:0] LIMIT_X = SW'(MAX_WIDTH - 1);
    localparam logic [SW-1:0] LIMIT_Y = SW'(MAX_HEIGHT - 1);

    ctd_pkg::back_state_t  state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [SW-1:0]         quot_x_reg, quot_x_next;
    logic [SW-1:0]         quot_y_reg, quot_y_next;
    logic [NW-1:0]         rem_x_reg, rem_x_next;
    logic [NW-1:0]         rem_y_reg, rem_y_next;
    logic [NW-1:0]         divisor_reg, divisor_next;
    ctd_pkg::result_word_t out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    logic [NW:0]           shift_x, shift_y, diff_x, diff_y;
    logic                  load_out;

    // One restoring quotient bit per cycle for each coordinate.
    assign shift_x = {rem_x_reg, quot_x_reg[SW-1]};
    assign shift_y = {rem_y_reg, quot_y_reg[SW-1]};
    assign diff_x  = shift_x - {1'b0, divisor_reg};
    assign diff_y  = shift_y - {1'b0, divisor_reg};

    assign load_out = (state_reg == ctd_pkg::ST_HOLD) && (!out_valid_reg || m_ready);
    assign q_pop    = (state_reg == ctd_pkg::ST_IDLE) && !q_status.empty;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        quot_x_next    = quot_x_reg;
        quot_y_next    = quot_y_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        divisor_next   = divisor_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ctd_pkg::ST_IDLE: begin
                if (!q_status.empty) begin
                    quot_x_next  = q_head.sum_x;
                    quot_y_next  = q_head.sum_y;
                    divisor_next = q_head.count;
                    rem_x_next   = '0;
                    rem_y_next   = '0;
                    step_next    = '0;
                    state_next   = ctd_pkg::ST_DIV;
                end
            end
            ctd_pkg::ST_DIV: begin
                if (!diff_x[NW]) begin
                    rem_x_next  = diff_x[NW-1:0];
                    quot_x_next = {quot_x_reg[SW-2:0], 1'b1};
                end else begin
                    rem_x_next  = shift_x[NW-1:0];
                    quot_x_next = {quot_x_reg[SW-2:0], 1'b0};
                end
                if (!diff_y[NW]) begin
                    rem_y_next  = diff_y[NW-1:0];
                    quot_y_next = {quot_y_reg[SW-2:0], 1'b1};
                end else begin
                    rem_y_next  = shift_y[NW-1:0];
                    quot_y_next = {quot_y_reg[SW-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(SW - 1)) begin
                    state_next = ctd_pkg::ST_HOLD;
                end
            end
            ctd_pkg::ST_HOLD: begin
                if (load_out) begin
                    out_valid_next       = 1'b1;
                    out_next.pixel_count = divisor_reg;
                    out_next.found       = (divisor_reg != '0);
                    if (divisor_reg == '0) begin
                        out_next.center_x = '0;
                        out_next.center_y = '0;
                    end else begin
                        out_next.center_x = (quot_x_reg > LIMIT_X)
                            ? LIMIT_X[ctd_pkg::COORD_W-1:0]
                            : quot_x_reg[ctd_pkg::COORD_W-1:0];
                        out_next.center_y = (quot_y_reg > LIMIT_Y)
                            ? LIMIT_Y[ctd_pkg::COORD_W-1:0]
                            : quot_y_reg[ctd_pkg::COORD_W-1:0];
                    end
                    state_next = ctd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ctd_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        quot_x_reg  <= quot_x_next;
        quot_y_reg  <= quot_y_next;
        rem_x_reg   <= rem_x_next;
        rem_y_reg   <= rem_y_next;
        divisor_reg <= divisor_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ctd_pkg::ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/threshold_centroid_core.sv -----
// Threshold centroid of a grayscale frame.
// Input channel (s_valid/s_ready/s_data): one 8-bit pixel word per cycle while
// s_ready is high, in raster order; end_of_frame marks the last pixel of a
// frame. The core tracks column and row itself from the image_width register.
// Output channel (m_valid/m_ready/m_data): one result word per frame with the
// truncated mean column and row of pixels at or above threshold, the hit
// count and a found flag (zero coordinates when no pixel qualified).
// Configuration: APB registers threshold (0x0) and image_width (0x4).
// Throughput: one pixel per cycle while accumulating and the queue has room.
// Frame totals go into a two-entry queue; a restoring divider produces one
// quotient bit per cycle for both coordinates in its DIV state, registers the
// result in HOLD and takes the next frame's totals only in IDLE. Frames that
// end faster than the divider finishes back up in the queue; s_ready drops
// while the queue is full. A stalled receiver holds the result register, the
// divider then waits, and the queue fills behind it.
// Reset clears counters, sums, queue and output and loads threshold 100 and
// image_width 640.
`default_nettype none

module threshold_centroid_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire ctd_pkg::pixel_word_t         s_data,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output ctd_pkg::result_word_t             m_data,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ctd_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ctd_pkg::DATA_W-1:0]   pwdata,
    output logic [ctd_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [7:0]             threshold_reg, threshold_next;
    logic [10:0]            image_width_reg, image_width_next;
    logic                   reg_index;
    logic                   cfg_write;

    logic                   q_push, q_pop;
    ctd_pkg::totals_t       q_push_data, q_head;
    ctd_pkg::queue_status_t q_status;

    assign pready    = 1'b1;
    assign reg_index = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        threshold_next   = threshold_reg;
        image_width_next = image_width_reg;
        if (cfg_write) begin
            if (reg_index == ctd_pkg::REG_THRESHOLD) begin
                threshold_next = pwdata[7:0];
            end else begin
                image_width_next = pwdata[10:0];
            end
        end
    end

    always_comb begin
        if (reg_index == ctd_pkg::REG_THRESHOLD) begin
            prdata = ctd_pkg::DATA_W'(threshold_reg);
        end else begin
            prdata = ctd_pkg::DATA_W'(image_width_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg   <= ctd_pkg::THRESHOLD_RESET;
            image_width_reg <= ctd_pkg::WIDTH_RESET;
        end else begin
            threshold_reg   <= threshold_next;
            image_width_reg <= image_width_next;
        end
    end

    ctd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .threshold   (threshold_reg),
        .image_width (image_width_reg),
        .q_status    (q_status),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    ctd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .status    (q_status),
        .head      (q_head)
    );

    ctd_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A frame's totals are waiting for the divider right after its last word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.end_of_frame) |=> !q_status.empty)
        else $error("frame totals lost after end of frame");

    // An empty frame reports zeros everywhere.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.found) |->
            (m_data.center_x == '0 && m_data.center_y == '0 && m_data.pixel_count == '0))
        else $error("empty frame result not zero");

    // The found flag agrees with the hit count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.found == (m_data.pixel_count != '0)))
        else $error("found flag disagrees with pixel count");

endmodule

`default_nettype wire
